/* sv/mbet_pkg.sv */
// shared types, constants and register codes for the escape-time unit
`default_nettype none

package mbet_pkg;

    // fixed-point format and field widths
    localparam int FRAC_BITS  = 28;
    localparam int IMAGE_SIZE = 2048;
    localparam int COORD_W    = 32;
    localparam int PIX_W      = 11;
    localparam int STEP_W     = 29;
    localparam int ITER_W     = 8;
    localparam int MAG_W      = 32;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int SQ_W       = PROD_W - FRAC_BITS;
    localparam int Z_W        = 34;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    localparam logic [PIX_W-1:0]  PIX_MAX = PIX_W'(IMAGE_SIZE - 1);
    localparam logic [SQ_W:0]     ESC_BOUND = (SQ_W + 1)'(4) << FRAC_BITS;
    localparam logic [ITER_W-1:0] ITER_MIN = ITER_W'(1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = CFG_IDX_W'(3);

    // register reset values: -1.6, -1.2, 0.0011719, 255
    localparam logic [COORD_W-1:0] ORIGIN_RE_RST = 32'hE666_6666;
    localparam logic [COORD_W-1:0] ORIGIN_IM_RST = 32'hECCC_CCCD;
    localparam logic [STEP_W-1:0]  STEP_RST      = STEP_W'(314573);
    localparam logic [ITER_W-1:0]  MAX_ITER_RST  = ITER_W'(255);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CROSS,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        OP_STEP_X,
        OP_STEP_Y,
        OP_RE_RE,
        OP_IM_IM,
        OP_RE_IM
    } t_opsel;

    typedef struct packed {
        t_opsel opsel;
        logic   s_ready;
        logic   ld_cre;
        logic   ld_cim;
        logic   ld_sr;
        logic   step_zr;
        logic   ld_zi;
        logic   ld_out;
    } t_ctrl;

    typedef struct packed {
        logic s_valid;
        logic stop;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* sv/mbet_mul.sv */
// shared unsigned multiplier with registered product
`default_nettype none

module mbet_mul (
    input  wire logic                       i_clk,
    input  wire logic [mbet_pkg::MAG_W-1:0]  i_a,
    input  wire logic [mbet_pkg::MAG_W-1:0]  i_b,
    output logic      [mbet_pkg::PROD_W-1:0] o_prod
);
    import mbet_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* sv/mbet_ctrl.sv */
// sequencer for the coordinate products and the iteration loop
`default_nettype none

module mbet_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mbet_pkg::t_stat i_stat,
    output mbet_pkg::t_ctrl      o_ctrl
);
    import mbet_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_stat.s_valid) n_state = ST_MUL_X;
            ST_MUL_X:  n_state = ST_MUL_Y;
            ST_MUL_Y:  n_state = ST_SQ_RE;
            ST_SQ_RE:  n_state = ST_SQ_IM;
            ST_SQ_IM:  n_state = ST_CROSS;
            ST_CROSS:  n_state = i_stat.stop ? ST_FINISH : ST_UPDATE;
            ST_UPDATE: n_state = ST_SQ_IM;
            ST_FINISH: if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.opsel = OP_RE_RE;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.s_ready = 1'b1;
            end
            ST_MUL_X: begin
                o_ctrl.opsel = OP_STEP_X;
            end
            ST_MUL_Y: begin
                o_ctrl.opsel  = OP_STEP_Y;
                o_ctrl.ld_cre = 1'b1;
            end
            ST_SQ_RE: begin
                o_ctrl.opsel  = OP_RE_RE;
                o_ctrl.ld_cim = 1'b1;
            end
            ST_SQ_IM: begin
                o_ctrl.opsel = OP_IM_IM;
                o_ctrl.ld_sr = 1'b1;
            end
            ST_CROSS: begin
                o_ctrl.opsel   = OP_RE_IM;
                o_ctrl.step_zr = !i_stat.stop;
            end
            ST_UPDATE: begin
                // square of the fresh real part overlaps the imaginary update
                o_ctrl.opsel = OP_RE_RE;
                o_ctrl.ld_zi = 1'b1;
            end
            ST_FINISH: begin
                o_ctrl.ld_out = i_stat.out_free;
            end
            default: begin
                o_ctrl.s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/mandelbrot_escape_time_unit.sv */
// top level of the escape-time unit: config registers, datapath, output register
`default_nettype none

// usage
// - config channel (i_cfg_*): index 0 origin_re, 1 origin_im, 2 step, 3 max_iter;
//   always ready, other indexes are dropped; write only while the unit is idle
// - input stream (s side): one item per pixel, tdata = pixel_x, pixel_y;
//   coordinates past the image edge are clamped to the last pixel
// - output stream (m side): one item per pixel, tdata = iter_count, in_set
// - one shared 32x32 multiplier does every product: two for the coordinate,
//   then three per iteration (re*re, im*im, re*im); the real-part update runs
//   beside the cross product
// - tready on the s side is high only in the idle state; the multiplier port is
//   the limit on rate
// - a finished result sits in the output register; a stalled receiver holds it
//   there while the next pixel is already taken and worked on; the unit waits
//   only when that next result is done and the register is still full
// - reset (synchronous, active low) loads the default view and empties the
//   pipeline; no clearing pass is needed
module mandelbrot_escape_time_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [mbet_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mbet_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [mbet_pkg::S_DATA_W-1:0]       i_s_tdata,  // pixel_x[10:0], pixel_y[21:11]
    // result items
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic      [mbet_pkg::M_DATA_W-1:0]       o_m_tdata   // iter_count[7:0], in_set[8]
);
    import mbet_pkg::*;

    // config registers
    logic        [COORD_W-1:0] r_origin_re;
    logic        [COORD_W-1:0] r_origin_im;
    logic        [STEP_W-1:0]  r_step;
    logic        [ITER_W-1:0]  r_max_iter;

    // per-pixel working state
    logic        [PIX_W-1:0]   r_px;
    logic        [PIX_W-1:0]   r_py;
    logic        [ITER_W-1:0]  r_limit;
    logic        [ITER_W-1:0]  r_cnt;
    logic signed [COORD_W-1:0] r_c_re;
    logic signed [COORD_W-1:0] r_c_im;
    logic        [SQ_W-1:0]    r_sr;
    logic        [MAG_W-1:0]   r_zr_mag;
    logic                      r_zr_neg;
    logic        [MAG_W-1:0]   r_zi_mag;
    logic                      r_zi_neg;
    logic                      r_cross_neg;

    // output register
    logic                      r_m_valid;
    logic        [ITER_W-1:0]  r_m_cnt;
    logic                      r_m_in_set;

    t_ctrl                     ctl;
    t_stat                     stat;

    logic        [MAG_W-1:0]   mul_a;
    logic        [MAG_W-1:0]   mul_b;
    logic        [PROD_W-1:0]  prod;

    logic        [PIX_W-1:0]   px_in;
    logic        [PIX_W-1:0]   py_in;
    logic        [SQ_W-1:0]    si;
    logic        [SQ_W:0]      sq_sum;
    logic                      escaped;
    logic signed [Z_W-1:0]     zr_next;
    logic        [Z_W-1:0]     cross_q;
    logic        [Z_W-1:0]     cross_qr;
    logic signed [Z_W-1:0]     cross_s;
    logic signed [Z_W-1:0]     zi_next;
    logic                      s_accept;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = ctl.s_ready;
    assign s_accept    = i_s_tvalid && ctl.s_ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= ORIGIN_RE_RST;
            r_origin_im <= ORIGIN_IM_RST;
            r_step      <= STEP_RST;
            r_max_iter  <= MAX_ITER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ORIGIN_RE: r_origin_re <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_IM: r_origin_im <= i_cfg_data[COORD_W-1:0];
                REG_STEP:      r_step      <= i_cfg_data[STEP_W-1:0];
                REG_MAX_ITER:  r_max_iter  <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp pixel coordinates to the image
    assign px_in = (i_s_tdata[PIX_W-1:0] > PIX_MAX) ? PIX_MAX : i_s_tdata[PIX_W-1:0];
    assign py_in = (i_s_tdata[2*PIX_W-1:PIX_W] > PIX_MAX) ? PIX_MAX
                                                          : i_s_tdata[2*PIX_W-1:PIX_W];

    // operand select for the shared multiplier (magnitudes only)
    always_comb begin
        case (ctl.opsel)
            OP_STEP_X: begin
                mul_a = MAG_W'(r_step);
                mul_b = MAG_W'(r_px);
            end
            OP_STEP_Y: begin
                mul_a = MAG_W'(r_step);
                mul_b = MAG_W'(r_py);
            end
            OP_IM_IM: begin
                mul_a = r_zi_mag;
                mul_b = r_zi_mag;
            end
            OP_RE_IM: begin
                mul_a = r_zr_mag;
                mul_b = r_zi_mag;
            end
            default: begin
                mul_a = r_zr_mag;
                mul_b = r_zr_mag;
            end
        endcase
    end

    mbet_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // escape test: re^2 + im^2 against 4
    assign si      = prod[PROD_W-1:FRAC_BITS];
    assign sq_sum  = (SQ_W + 1)'(r_sr) + (SQ_W + 1)'(si);
    assign escaped = sq_sum >= ESC_BOUND;

    // below the bound both squares fit in FRAC_BITS+2 bits
    assign zr_next = $signed(Z_W'(r_sr[FRAC_BITS+1:0]))
                   - $signed(Z_W'(si[FRAC_BITS+1:0]))
                   + Z_W'(r_c_re);

    // cross term floor(2*re*im), rounded toward minus infinity when negative
    assign cross_q  = prod[FRAC_BITS-1 +: Z_W];
    assign cross_qr = cross_q + Z_W'(|prod[FRAC_BITS-2:0]);
    assign cross_s  = r_cross_neg ? -$signed(cross_qr) : $signed(cross_q);
    assign zi_next  = cross_s + Z_W'(r_c_im);

    assign stat.s_valid  = i_s_tvalid;
    assign stat.stop     = (r_cnt >= r_limit) || escaped;
    assign stat.out_free = !r_m_valid || i_m_tready;

    mbet_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctl)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_px     <= px_in;
            r_py     <= py_in;
            r_limit  <= (r_max_iter == '0) ? ITER_MIN : r_max_iter;
            r_cnt    <= '0;
            r_zr_mag <= '0;
            r_zr_neg <= 1'b0;
            r_zi_mag <= '0;
            r_zi_neg <= 1'b0;
        end
        if (ctl.ld_cre) begin
            r_c_re <= $signed(r_origin_re + prod[COORD_W-1:0]);
        end
        if (ctl.ld_cim) begin
            r_c_im <= $signed(r_origin_im + prod[COORD_W-1:0]);
        end
        if (ctl.ld_sr) begin
            r_sr <= prod[PROD_W-1:FRAC_BITS];
        end
        if (ctl.step_zr) begin
            // old signs go with the cross product issued this cycle
            r_cross_neg <= r_zr_neg ^ r_zi_neg;
            r_zr_neg    <= zr_next[Z_W-1];
            r_zr_mag    <= zr_next[Z_W-1] ? MAG_W'(-zr_next) : MAG_W'(zr_next);
            r_cnt       <= r_cnt + ITER_W'(1);
        end
        if (ctl.ld_zi) begin
            r_zi_neg <= zi_next[Z_W-1];
            r_zi_mag <= zi_next[Z_W-1] ? MAG_W'(-zi_next) : MAG_W'(zi_next);
        end
    end

    // output register, parts the loop from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (ctl.ld_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld_out) begin
            r_m_cnt    <= r_cnt;
            r_m_in_set <= r_cnt == r_limit;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(M_DATA_W - ITER_W - 1){1'b0}}, r_m_in_set, r_m_cnt};

    // count never passes the limit while a pixel is at work
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ctl.s_ready |-> r_cnt <= r_limit)
        else $error("iteration count above limit");

    // another iteration only starts below the limit
    a_step_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.step_zr |-> r_cnt < r_limit)
        else $error("iteration past limit");

    // a result always counts at least one iteration
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[ITER_W-1:0] != '0)
        else $error("zero iteration count");

    // a new result only appears from the finish step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(ctl.ld_out))
        else $error("output loaded outside finish");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the escape-time unit: directed views, then random windows and random registers

module tb_top;

    import mbet_pkg::*;

    // spare register indexes, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = CFG_IDX_W'(255);

    // magnitude cap applied to every shifted product
    localparam logic [63:0] MAG_CAP = 64'd1 << 61;

    // exact fixed-point values used by the directed views
    localparam logic [31:0] FIX_MINUS_TWO = 32'hE000_0000;
    localparam logic [31:0] FIX_ONE       = 32'h1000_0000;

    localparam int RANDOM_PIXELS = 1130;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] x;
    } pixel_t;

    typedef struct packed {
        logic [ITER_W-1:0] iter_count;
        logic              in_set;
    } escape_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;   // pixel_x[10:0], pixel_y[21:11], zero fill
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;        // iter_count[7:0], in_set[8], zero fill

    // register copies used by the predictor
    logic [COORD_W-1:0] view_origin_re = ORIGIN_RE_RST;
    logic [COORD_W-1:0] view_origin_im = ORIGIN_IM_RST;
    logic [STEP_W-1:0]  view_step      = STEP_RST;
    logic [ITER_W-1:0]  view_max_iter  = MAX_ITER_RST;

    pixel_t  pixel_queue[$];
    escape_t expected_escapes[$];

    int mismatches = 0;
    int pixels_sent = 0;
    int escapes_seen = 0;
    int limit_hits = 0;
    int reg_writes = 0;

    always #10 i_clk = ~i_clk;

    mandelbrot_escape_time_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // floor(a*b / 2^shift) from the exact wide product, magnitude capped
    function automatic longint scaled_product(longint a, longint b, int shift);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  q;
        logic [127:0] prod;
        logic [127:0] shifted;
        logic         negative;
        negative = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        shifted = prod >> shift;
        if (shifted > {64'd0, MAG_CAP})
            q = MAG_CAP;
        else
            q = shifted[63:0];
        if (!negative)
            return longint'(q);
        // rounding toward minus infinity on the negative side
        if ((prod & ((128'd1 << shift) - 128'd1)) != 0)
            q = q + 64'd1;
        return -longint'(q);
    endfunction

    // origin + step*pixel, wrapped to 32 bits and sign extended
    function automatic longint pixel_coord(logic [COORD_W-1:0] origin, logic [PIX_W-1:0] pix);
        logic [COORD_W-1:0] sum;
        sum = origin + COORD_W'({21'd0, view_step} * {29'd0, pix});
        return longint'($signed(sum));
    endfunction

    function automatic escape_t predict_escape(pixel_t p);
        longint      c_re;
        longint      c_im;
        longint      zr;
        longint      zi;
        longint      sq_re;
        longint      sq_im;
        longint      z_prod;
        logic [63:0] mag_sum;
        int unsigned lim;
        int unsigned cnt;
        escape_t     r;
        c_re = pixel_coord(view_origin_re, p.x);
        c_im = pixel_coord(view_origin_im, p.y);
        lim = (view_max_iter == '0) ? 1 : int'(view_max_iter);
        zr = 0;
        zi = 0;
        cnt = 0;
        while (1) begin
            sq_re = scaled_product(zr, zr, FRAC_BITS);
            sq_im = scaled_product(zi, zi, FRAC_BITS);
            mag_sum = 64'(sq_re) + 64'(sq_im);
            if (cnt >= lim || mag_sum >= 64'(ESC_BOUND))
                break;
            z_prod = scaled_product(zr, zi, FRAC_BITS - 1);
            zr = sq_re - sq_im + c_re;
            zi = z_prod + c_im;
            cnt++;
        end
        r.iter_count = ITER_W'(cnt);
        r.in_set = (cnt == lim);
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ORIGIN_RE: view_origin_re = data;
            REG_ORIGIN_IM: view_origin_im = data;
            REG_STEP:      view_step = data[STEP_W-1:0];
            REG_MAX_ITER:  view_max_iter = data[ITER_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic queue_pixel(input int x, input int y);
        pixel_t p;
        p.x = PIX_W'(x);
        p.y = PIX_W'(y);
        pixel_queue.push_back(p);
    endtask

    // every pixel sent and every result back, then a short settle
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || i_s_tvalid || expected_escapes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // pixel driver: bursts of random length separated by random gaps
    int     burst_left = 0;
    int     gap_left = 0;
    pixel_t next_pixel;

    always @(posedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || o_s_tready)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                next_pixel = pixel_queue.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {2'b00, next_pixel.y, next_pixel.x};
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 8);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 4);
                        2: gap_left = $urandom_range(5, 40);
                        default: gap_left = $urandom_range(41, 250);
                    endcase
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result stall: a 32-bit pattern rotated each cycle, redrawn whenever the phase counter wraps
    logic [31:0] stall_pattern = '1;
    logic [5:0]  stall_phase = '0;

    always @(posedge i_clk) begin
        if (stall_phase == '0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= '1;
                1: stall_pattern <= $urandom;
                2: stall_pattern <= $urandom | $urandom;
                default: stall_pattern <= $urandom & $urandom & $urandom;
            endcase
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
        end
        stall_phase <= stall_phase + 6'd1;
        i_m_tready <= stall_pattern[0];
    end

    // monitor: predict on every accepted pixel, check every accepted result
    escape_t want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_escapes.push_back(predict_escape(pixel_t'(i_s_tdata[2*PIX_W-1:0])));
                pixels_sent++;
            end
            if (o_m_tvalid && i_m_tready) begin
                escapes_seen++;
                if (o_m_tdata[ITER_W])
                    limit_hits++;
                if (expected_escapes.size() == 0) begin
                    report_mismatch($sformatf("result %h with no pixel pending", o_m_tdata));
                end else begin
                    want = expected_escapes.pop_front();
                    if (o_m_tdata[ITER_W-1:0] != want.iter_count)
                        report_mismatch($sformatf("iter_count %0d, expected %0d",
                                                  o_m_tdata[ITER_W-1:0], want.iter_count));
                    if (o_m_tdata[ITER_W] != want.in_set)
                        report_mismatch($sformatf("in_set %0b, expected %0b",
                                                  o_m_tdata[ITER_W], want.in_set));
                    if (o_m_tdata[M_DATA_W-1:ITER_W+1] != '0)
                        report_mismatch($sformatf("fill bits %h not zero",
                                                  o_m_tdata[M_DATA_W-1:ITER_W+1]));
                end
            end
        end
    end

    initial begin
        #120_000_000;
        $display("timeout with %0d results outstanding", expected_escapes.size());
        $display("FAIL mandelbrot_escape_time_unit");
        $finish;
    end

    int random_left;
    int batch;
    int mi;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default view: image corners, the origin (deep inside) and a point on the real axis
        queue_pixel(0, 0);
        queue_pixel(2047, 2047);
        queue_pixel(1365, 1024);
        queue_pixel(2047, 0);
        queue_pixel(0, 2047);
        queue_pixel(1024, 1024);
        wait_idle();

        // limit of zero acts as one; oversized step and top origins wrap the coordinate;
        // writes to spare indexes are dropped
        write_reg(REG_MAX_ITER, 32'h0000_0000);
        write_reg(REG_STEP, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_IM, 32'h8000_0000);
        write_reg(REG_SPARE_FIRST, 32'h0000_0007);
        write_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(2047, 2047);
        queue_pixel(1, 2046);
        wait_idle();

        // c = -2 sits exactly on the escape bound; -1 and 0 stay bounded; far pixels wrap
        write_reg(REG_MAX_ITER, 32'h0000_00FF);
        write_reg(REG_STEP, FIX_ONE);
        write_reg(REG_ORIGIN_RE, FIX_MINUS_TWO);
        write_reg(REG_ORIGIN_IM, 32'h0000_0000);
        queue_pixel(0, 0);
        queue_pixel(1, 0);
        queue_pixel(2, 0);
        queue_pixel(3, 0);
        queue_pixel(0, 1);
        queue_pixel(2047, 2047);
        wait_idle();

        // upper data bits of the limit are dropped; smallest nonzero step at the origin extremes
        write_reg(REG_MAX_ITER, 32'h0000_0105);
        write_reg(REG_STEP, 32'h0000_0001);
        write_reg(REG_ORIGIN_RE, 32'h8000_0000);
        write_reg(REG_ORIGIN_IM, 32'h7FFF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(2047, 2047);
        queue_pixel(1024, 512);
        wait_idle();

        // limit of one with zero step at c_re = 0; origin_im keeps its previous value
        write_reg(REG_MAX_ITER, 32'h0000_0001);
        write_reg(REG_STEP, 32'h0000_0000);
        write_reg(REG_ORIGIN_RE, 32'h0000_0000);
        queue_pixel(777, 1290);
        queue_pixel(2047, 0);
        wait_idle();

        // random phases: mostly windows over the set, some fully random registers
        random_left = RANDOM_PIXELS;
        while (random_left > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_ORIGIN_RE, $urandom);
                write_reg(REG_ORIGIN_IM, $urandom);
                write_reg(REG_STEP, $urandom);
                write_reg(REG_MAX_ITER, $urandom);
                batch = 45;
            end else begin
                // left edge near -2.2..-1.6, top edge near -1.3..-0.9
                write_reg(REG_ORIGIN_RE, 32'(-590558003 + int'($urandom_range(0, 161061274))));
                write_reg(REG_ORIGIN_IM, 32'(-348966093 + int'($urandom_range(0, 107374182))));
                write_reg(REG_STEP, $urandom_range(65536, 360000));
                if ($urandom_range(0, 4) == 0) begin
                    mi = 255;
                    batch = 12;
                end else begin
                    mi = $urandom_range(1, 64);
                    batch = 50;
                end
                write_reg(REG_MAX_ITER, {24'($urandom), 8'(mi)});
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE_FIRST), int'(REG_SPARE_LAST))),
                          $urandom);
            if (batch > random_left)
                batch = random_left;
            repeat (batch) queue_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
            random_left -= batch;
            wait_idle();
        end

        repeat (32) @(posedge i_clk);
        $display("covered %0d pixels and %0d results, %0d of them at the iteration limit",
                 pixels_sent, escapes_seen, limit_hits);
        $display("over %0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("PASS mandelbrot_escape_time_unit");
        end else begin
            $display("FAIL mandelbrot_escape_time_unit");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/mbet_pkg.sv
sv/mbet_mul.sv
sv/mbet_ctrl.sv
sv/mandelbrot_escape_time_unit.sv
sim/tb_top.sv
